[rtl/wmad_pkg.sv]
// Shared types and constants for the window max absolute difference monitor.
`timescale 1ns / 1ps
`default_nettype none
package wmad_pkg;

  localparam int SAMPLE_W = 30;
  localparam int DIFF_W   = 30;
  localparam int RESULT_W = 31;

  localparam logic [RESULT_W-1:0] NOT_SETTLED = 31'h7fff_ffff;

  typedef struct packed {
    logic              token;
    logic [DIFF_W-1:0] best;
  } sweep_link_t;

endpackage
`default_nettype wire

[rtl/window_max_abs_difference_core.sv]
// Top level of the window max absolute difference stability monitor.
// Usage:
//   Input channel (in_valid / in_stall): in_action = 0 feeds in_sample, a
//   30-bit signed delay measurement; in_action = 1 restarts the history and
//   gives no result. Output channel (out_valid / out_stall): one result per
//   feed, out_max_difference and out_settled.
//   A settled feed waits for the sweep token to pass once through the
//   WINDOW - 1 cells of the chain; a feed before warmup skips the sweep.
//   One feed is in flight at a time: a new feed is taken only once the last
//   result has gone to the output register; in_stall is high while a feed
//   is in progress.
//   Reset: fill count and control clear; stored samples and differences are
//   left as they are and are rewritten before use.
//   When the receiver stalls, the result holds on the output register and the
//   finished next result waits until the register frees up.
`timescale 1ns / 1ps
`default_nettype none
module window_max_abs_difference_core #(
  parameter int RING_DEPTH = 16,
  parameter int WINDOW     = 8,
  parameter int WARMUP     = 4
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic                            in_action,
  input  wire logic signed [wmad_pkg::SAMPLE_W-1:0] in_sample,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic [wmad_pkg::RESULT_W-1:0]        out_max_difference,
  output logic                                 out_settled
);
  import wmad_pkg::*;

  localparam int CW    = $clog2(RING_DEPTH);
  localparam int NCELL = WINDOW - 1;
  localparam logic [CW-1:0] COUNT_MAX = CW'(RING_DEPTH - 1);

  typedef enum logic [1:0] {ST_IDLE, ST_CALC, ST_SWEEP, ST_HOLD} state_t;

  state_t                state_r;
  logic [CW-1:0]         count_r;
  logic [CW-1:0]         snap_r;
  logic [SAMPLE_W-1:0]   sample_r;
  logic [SAMPLE_W-1:0]   prev_r;
  logic                  go_r;
  logic [RESULT_W-1:0]   res_max_r;
  logic                  res_settled_r;
  logic                  out_valid_r;
  logic [RESULT_W-1:0]   out_max_r;
  logic                  out_settled_r;

  logic                  in_acc;
  logic                  out_free;
  logic                  settled;
  logic                  shift_en;
  logic [SAMPLE_W:0]     diff_s;
  logic [SAMPLE_W:0]     diff_abs;
  logic [DIFF_W-1:0]     mag;

  sweep_link_t           link [NCELL+1];
  logic [DIFF_W-1:0]     diff_q [NCELL];

  assign in_stall = (state_r != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;
  assign settled  = 32'(snap_r) >= 32'(WARMUP);
  assign shift_en = (state_r == ST_CALC);

  assign diff_s   = {sample_r[SAMPLE_W-1], sample_r} - {prev_r[SAMPLE_W-1], prev_r};
  assign diff_abs = diff_s[SAMPLE_W] ? (~diff_s + 1'b1) : diff_s;
  assign mag      = (snap_r == '0) ? '0 : diff_abs[DIFF_W-1:0];

  assign link[0] = '{token: go_r, best: '0};

  for (genvar j = 0; j < NCELL; j++) begin : g_cell
    logic [DIFF_W-1:0] cell_in;
    if (j == 0) begin : g_head
      assign cell_in = mag;
    end else begin : g_body
      assign cell_in = diff_q[j-1];
    end
    wmad_cell #(
      .IDX (j),
      .CW  (CW)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .shift_en (shift_en),
      .shift_in (cell_in),
      .count    (snap_r),
      .link_in  (link[j]),
      .diff_q   (diff_q[j]),
      .link_out (link[j+1])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      go_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      go_r <= (state_r == ST_CALC) && settled;
      if (out_valid_r && !out_stall && (state_r != ST_HOLD)) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            if (in_action) begin
              count_r <= '0;
            end else begin
              sample_r <= in_sample;
              snap_r   <= count_r;
              state_r  <= ST_CALC;
            end
          end
        end
        ST_CALC: begin
          prev_r <= sample_r;
          if (count_r < COUNT_MAX) begin
            count_r <= count_r + 1'b1;
          end
          if (settled) begin
            state_r <= ST_SWEEP;
          end else begin
            res_max_r     <= NOT_SETTLED;
            res_settled_r <= 1'b0;
            state_r       <= ST_HOLD;
          end
        end
        ST_SWEEP: begin
          if (link[NCELL].token) begin
            res_max_r     <= {1'b0, link[NCELL].best};
            res_settled_r <= 1'b1;
            state_r       <= ST_HOLD;
          end
        end
        ST_HOLD: begin
          if (out_free) begin
            out_valid_r   <= 1'b1;
            out_max_r     <= res_max_r;
            out_settled_r <= res_settled_r;
            state_r       <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid          = out_valid_r;
  assign out_max_difference = out_max_r;
  assign out_settled        = out_settled_r;

endmodule
`default_nettype wire

[rtl/wmad_cell.sv]
// One cell of the difference chain: holds one stored difference and folds it into the sweep.
`timescale 1ns / 1ps
`default_nettype none
module wmad_cell #(
  parameter int IDX = 0,
  parameter int CW  = 4
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      shift_en,
  input  wire logic [wmad_pkg::DIFF_W-1:0] shift_in,
  input  wire logic [CW-1:0]             count,
  input  wire wmad_pkg::sweep_link_t     link_in,
  output logic [wmad_pkg::DIFF_W-1:0]    diff_q,
  output wmad_pkg::sweep_link_t          link_out
);
  import wmad_pkg::*;

  logic [DIFF_W-1:0] diff_r;
  logic [DIFF_W-1:0] best_r;
  logic              token_r;
  logic              in_window;

  assign in_window = 32'(IDX) < 32'(count);

  always_ff @(posedge clk) begin
    if (shift_en) begin
      diff_r <= shift_in;
    end
    if (in_window && (diff_r > link_in.best)) begin
      best_r <= diff_r;
    end else begin
      best_r <= link_in.best;
    end
    if (!rst_n) begin
      token_r <= 1'b0;
    end else begin
      token_r <= link_in.token;
    end
  end

  assign diff_q   = diff_r;
  assign link_out = '{token: token_r, best: best_r};

endmodule
`default_nettype wire

[rtl/wmad_checker.sv]
// Port-level checks for the window max absolute difference monitor, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module wmad_checker (
  input wire logic                           clk,
  input wire logic                           rst_n,
  input wire logic                           in_valid,
  input wire logic                           in_stall,
  input wire logic                           in_action,
  input wire logic                           out_valid,
  input wire logic                           out_stall,
  input wire logic [wmad_pkg::RESULT_W-1:0]  out_max_difference,
  input wire logic                           out_settled
);
  import wmad_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_max_difference) && $stable(out_settled))
    else $error("stalled result changed or dropped");

  a_sentinel: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_settled |-> out_max_difference == NOT_SETTLED)
    else $error("unsettled result without sentinel");

  a_settled_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_settled |-> out_max_difference[RESULT_W-1] == 1'b0)
    else $error("settled result wider than 30 bits");

  a_feed_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && !in_action |=> in_stall)
    else $error("feed transaction did not start processing");

  a_restart_free: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_action |=> !in_stall)
    else $error("restart transaction blocked the input");

endmodule

bind window_max_abs_difference_core wmad_checker u_wmad_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_valid           (in_valid),
  .in_stall           (in_stall),
  .in_action          (in_action),
  .out_valid          (out_valid),
  .out_stall          (out_stall),
  .out_max_difference (out_max_difference),
  .out_settled        (out_settled)
);
`default_nettype wire
